@@ rtl/core/ltd_pkg.sv @@
// Shared types and constants for the line tag deframer.
`timescale 1ns / 1ps

package ltd_pkg;

    // Queue between the front and back parts
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Register reset values
    localparam logic [15:0] LINE_WORDS_RESET    = 16'd960;
    localparam logic [31:0] SEP_MARKER_RESET    = 32'h02ff_00ff;
    localparam logic [31:0] ACTIVE_MARKER_RESET = 32'h8000_00ff;
    localparam logic [31:0] BLANK_MARKER_RESET  = 32'hab00_00ff;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_LINE_WORDS    = 2'd0;
    localparam logic [1:0] REG_SEP_MARKER    = 2'd1;
    localparam logic [1:0] REG_ACTIVE_MARKER = 2'd2;
    localparam logic [1:0] REG_BLANK_MARKER  = 2'd3;

    // Line classes
    localparam logic [1:0] CLS_ACTIVE  = 2'd0;
    localparam logic [1:0] CLS_BLANK   = 2'd1;
    localparam logic [1:0] CLS_UNKNOWN = 2'd2;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_CLASS   = 1'b1;

    // Work handed from front to back
    typedef enum logic [1:0] {
        OP_SEP,
        OP_PAYLOAD,
        OP_CLASS
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] word;
        logic        last;
        logic [1:0]  cls;
    } op_t;

endpackage

@@ rtl/core/ltd_front.sv @@
// Front part: tracks line framing and turns capture words into back-end ops.
`timescale 1ns / 1ps

module ltd_front
    import ltd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [31:0] data_word,
    input  logic [15:0] line_words,
    input  logic [31:0] sep_marker,
    input  logic [31:0] active_marker,
    input  logic [31:0] blank_marker,
    output logic        push,
    output op_t         push_op
);

    typedef enum logic [2:0] {
        PH_PIXELS,
        PH_TAG,
        PH_PAY0,
        PH_PAY1,
        PH_LINETAG
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] word_index_reg, word_index_next;
    logic [1:0]  tag_cls;
    logic        run_done;

    // Classify a line tag; active wins over blanking on equal markers
    always_comb
    begin
        if (data_word == active_marker)
            tag_cls = CLS_ACTIVE;
        else if (data_word == blank_marker)
            tag_cls = CLS_BLANK;
        else
            tag_cls = CLS_UNKNOWN;
    end

    // Pixel run ends once index+1 reaches the length (zero acts as one)
    assign run_done = ({1'b0, word_index_reg} + 17'd1) >= {1'b0, line_words};

    // Next phase and op for the current beat
    always_comb
    begin
        phase_next      = phase_reg;
        word_index_next = word_index_reg;
        push            = 1'b0;
        push_op.kind    = OP_CLASS;
        push_op.word    = 32'd0;
        push_op.last    = 1'b0;
        push_op.cls     = tag_cls;
        if (accept)
        begin
            case (phase_reg)
                PH_PIXELS:
                begin
                    if (run_done)
                    begin
                        word_index_next = 16'd0;
                        phase_next      = PH_TAG;
                    end
                    else
                    begin
                        word_index_next = word_index_reg + 16'd1;
                    end
                end
                PH_TAG:
                begin
                    push = 1'b1;
                    if (data_word == sep_marker)
                    begin
                        push_op.kind = OP_SEP;
                        phase_next   = PH_PAY0;
                    end
                    else
                    begin
                        phase_next      = PH_PIXELS;
                        word_index_next = 16'd0;
                    end
                end
                PH_PAY0:
                begin
                    push         = 1'b1;
                    push_op.kind = OP_PAYLOAD;
                    push_op.word = data_word;
                    phase_next   = PH_PAY1;
                end
                PH_PAY1:
                begin
                    push         = 1'b1;
                    push_op.kind = OP_PAYLOAD;
                    push_op.word = data_word;
                    push_op.last = 1'b1;
                    phase_next   = PH_LINETAG;
                end
                PH_LINETAG:
                begin
                    push            = 1'b1;
                    phase_next      = PH_PIXELS;
                    word_index_next = 16'd0;
                end
                default:
                begin
                    phase_next      = PH_PIXELS;
                    word_index_next = 16'd0;
                end
            endcase
        end
    end

    // Framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PIXELS;
            word_index_reg <= 16'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            word_index_reg <= word_index_next;
        end
    end

endmodule

@@ rtl/core/ltd_queue.sv @@
// Short FIFO of ops between the front and back parts.
`timescale 1ns / 1ps

module ltd_queue
    import ltd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output logic full,
    output logic empty,
    output op_t  head_op
);

    op_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
        end
    end

endmodule

@@ rtl/core/ltd_back.sv @@
// Back part: runs the saturating counters and holds the result register.
`timescale 1ns / 1ps

module ltd_back
    import ltd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  op_t         head_op,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [31:0] payload_word,
    output logic        payload_last,
    output logic [1:0]  line_class,
    output logic [31:0] sep_total,
    output logic [31:0] active_total,
    output logic [31:0] blank_total,
    output logic [31:0] unknown_total
);

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hffff_ffff) ? v : v + 32'd1;
    endfunction

    logic        out_valid_reg;
    logic [31:0] sep_count_reg, sep_count_next;
    logic [31:0] active_count_reg, active_count_next;
    logic [31:0] blank_count_reg, blank_count_next;
    logic [31:0] unknown_count_reg, unknown_count_next;
    logic        kind_reg;
    logic [31:0] word_reg;
    logic        last_reg;
    logic [1:0]  cls_reg;
    logic [31:0] sep_tot_reg, active_tot_reg, blank_tot_reg, unknown_tot_reg;
    logic        slot_free;
    logic        makes_result;

    // Separator ops only bump a counter, so they never wait on the output
    assign slot_free    = !out_valid_reg || out_ready;
    assign makes_result = (head_op.kind != OP_SEP);
    assign pop          = head_valid && (slot_free || !makes_result);

    // Counter updates for the op at the head
    always_comb
    begin
        sep_count_next     = sep_count_reg;
        active_count_next  = active_count_reg;
        blank_count_next   = blank_count_reg;
        unknown_count_next = unknown_count_reg;
        if (pop)
        begin
            case (head_op.kind)
                OP_SEP:
                    sep_count_next = sat_inc(sep_count_reg);
                OP_CLASS:
                begin
                    case (head_op.cls)
                        CLS_ACTIVE: active_count_next  = sat_inc(active_count_reg);
                        CLS_BLANK:  blank_count_next   = sat_inc(blank_count_reg);
                        default:    unknown_count_next = sat_inc(unknown_count_reg);
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // Counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_count_reg     <= 32'd0;
            active_count_reg  <= 32'd0;
            blank_count_reg   <= 32'd0;
            unknown_count_reg <= 32'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            sep_count_reg     <= sep_count_next;
            active_count_reg  <= active_count_next;
            blank_count_reg   <= blank_count_next;
            unknown_count_reg <= unknown_count_next;
            if (pop && makes_result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, captured with the post-update totals
    always_ff @(posedge clk)
    begin
        if (pop && makes_result)
        begin
            if (head_op.kind == OP_CLASS)
            begin
                kind_reg <= KIND_CLASS;
                word_reg <= 32'd0;
                last_reg <= 1'b0;
                cls_reg  <= head_op.cls;
            end
            else
            begin
                kind_reg <= KIND_PAYLOAD;
                word_reg <= head_op.word;
                last_reg <= head_op.last;
                cls_reg  <= CLS_ACTIVE;
            end
            sep_tot_reg     <= sep_count_next;
            active_tot_reg  <= active_count_next;
            blank_tot_reg   <= blank_count_next;
            unknown_tot_reg <= unknown_count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign payload_word  = word_reg;
    assign payload_last  = last_reg;
    assign line_class    = cls_reg;
    assign sep_total     = sep_tot_reg;
    assign active_total  = active_tot_reg;
    assign blank_total   = blank_tot_reg;
    assign unknown_total = unknown_tot_reg;

endmodule

@@ rtl/core/line_tag_deframer.sv @@
// Top level of the line tag deframer: register port, front, queue and back.
`timescale 1ns / 1ps

// Takes one 32-bit capture word per beat and splits the stream into lines of
// line_words pixel words plus a tag. Pixel words are absorbed and give no
// result. A tag equal to sep_marker is counted and its next two words come out
// as payload results, then the following word is the line tag. Each line tag
// gives one classification result (active, blanking, unknown) with all four
// saturating totals. The block takes one word every cycle; the front framing
// logic handles each word as it is accepted and a four-entry op queue feeds the
// back counters, so in_ready drops only after the result register has been
// held by out_ready low long enough for the queue to fill. out_valid for a
// result rises once its op has left the op queue and been captured in the
// result register. Registers: line_words at 0x0,
// sep_marker at 0x4, active_marker at 0x8, blank_marker at 0xC; write only
// while the block is idle.

module line_tag_deframer
    import ltd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // capture words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [31:0] payload_word,
    output logic        payload_last,
    output logic [1:0]  line_class,
    output logic [31:0] sep_total,
    output logic [31:0] active_total,
    output logic [31:0] blank_total,
    output logic [31:0] unknown_total
);

    logic [15:0] line_words_reg;
    logic [31:0] sep_marker_reg;
    logic [31:0] active_marker_reg;
    logic [31:0] blank_marker_reg;
    logic        cfg_write;
    logic        accept;
    logic        push;
    op_t         push_op;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    op_t         head_op;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_words_reg    <= LINE_WORDS_RESET;
            sep_marker_reg    <= SEP_MARKER_RESET;
            active_marker_reg <= ACTIVE_MARKER_RESET;
            blank_marker_reg  <= BLANK_MARKER_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_LINE_WORDS:    line_words_reg    <= pwdata[15:0];
                REG_SEP_MARKER:    sep_marker_reg    <= pwdata;
                REG_ACTIVE_MARKER: active_marker_reg <= pwdata;
                REG_BLANK_MARKER:  blank_marker_reg  <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LINE_WORDS:    prdata = {16'd0, line_words_reg};
            REG_SEP_MARKER:    prdata = sep_marker_reg;
            REG_ACTIVE_MARKER: prdata = active_marker_reg;
            REG_BLANK_MARKER:  prdata = blank_marker_reg;
            default:           prdata = 32'd0;
        endcase
    end

    // Input beat
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    ltd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_word     (data_word),
        .line_words    (line_words_reg),
        .sep_marker    (sep_marker_reg),
        .active_marker (active_marker_reg),
        .blank_marker  (blank_marker_reg),
        .push          (push),
        .push_op       (push_op)
    );

    ltd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .full    (q_full),
        .empty   (q_empty),
        .head_op (head_op)
    );

    ltd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (!q_empty),
        .head_op       (head_op),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .payload_word  (payload_word),
        .payload_last  (payload_last),
        .line_class    (line_class),
        .sep_total     (sep_total),
        .active_total  (active_total),
        .blank_total   (blank_total),
        .unknown_total (unknown_total)
    );

endmodule

@@ tb/tb_line_tag_deframer.sv @@
// Self-checking testbench for the line tag deframer: driver, monitor and line predictor.
`timescale 1ns / 1ps

module tb_line_tag_deframer;
    import ltd_pkg::*;

    // Framing phases tracked by the predictor
    typedef enum logic [2:0] {
        FR_PIXELS,
        FR_TAG,
        FR_PAY0,
        FR_PAY1,
        FR_LINETAG
    } frame_phase_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] word;
        logic        last;
        logic [1:0]  cls;
        logic [31:0] sep_t;
        logic [31:0] act_t;
        logic [31:0] blk_t;
        logic [31:0] unk_t;
    } line_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] data_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        result_kind;
    logic [31:0] payload_word;
    logic        payload_last;
    logic [1:0]  line_class;
    logic [31:0] sep_total;
    logic [31:0] active_total;
    logic [31:0] blank_total;
    logic [31:0] unknown_total;

    line_tag_deframer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_word    (data_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .payload_word (payload_word),
        .payload_last (payload_last),
        .line_class   (line_class),
        .sep_total    (sep_total),
        .active_total (active_total),
        .blank_total  (blank_total),
        .unknown_total(unknown_total)
    );

    always #6 clk = ~clk;

    // Register shadow
    logic [15:0] cfg_line_words = LINE_WORDS_RESET;
    logic [31:0] cfg_sep        = SEP_MARKER_RESET;
    logic [31:0] cfg_active     = ACTIVE_MARKER_RESET;
    logic [31:0] cfg_blank      = BLANK_MARKER_RESET;

    // Predictor state
    frame_phase_t frame_phase = FR_PIXELS;
    logic [15:0]  pix_index = '0;
    logic [31:0]  cnt_sep = '0;
    logic [31:0]  cnt_active = '0;
    logic [31:0]  cnt_blank = '0;
    logic [31:0]  cnt_unknown = '0;

    logic [31:0]  capture_words[$];
    line_result_t expected_results[$];

    int  sender_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic in_taken = 1'b0;
    int  fail_count = 0;
    int  words_queued = 0;
    int  results_checked = 0;
    int  payload_seen = 0;
    int  line_ends_seen = 0;
    int  reg_writes = 0;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hffff_ffff) ? v : v + 32'd1;
    endfunction

    function automatic void push_result(input logic kind, input logic [31:0] w,
                                        input logic last, input logic [1:0] cls);
        line_result_t r;
        r.kind  = kind;
        r.word  = w;
        r.last  = last;
        r.cls   = cls;
        r.sep_t = cnt_sep;
        r.act_t = cnt_active;
        r.blk_t = cnt_blank;
        r.unk_t = cnt_unknown;
        expected_results.push_back(r);
    endfunction

    // Line tag: classify, bump its counter, start the next line
    function automatic void close_line(input logic [31:0] tag);
        logic [1:0] cls;
        if (tag == cfg_active)
        begin
            cls = CLS_ACTIVE;
            cnt_active = bump(cnt_active);
        end
        else if (tag == cfg_blank)
        begin
            cls = CLS_BLANK;
            cnt_blank = bump(cnt_blank);
        end
        else
        begin
            cls = CLS_UNKNOWN;
            cnt_unknown = bump(cnt_unknown);
        end
        push_result(KIND_CLASS, 32'd0, 1'b0, cls);
        frame_phase = FR_PIXELS;
        pix_index = '0;
    endfunction

    // Advance the framing state by one accepted capture word
    function automatic void deframe_word(input logic [31:0] w);
        case (frame_phase)
            FR_PIXELS:
                // a length of zero acts as one; a shortened length ends the run at once
                if ({1'b0, pix_index} + 17'd1 >= {1'b0, cfg_line_words})
                begin
                    pix_index = '0;
                    frame_phase = FR_TAG;
                end
                else
                begin
                    pix_index = pix_index + 16'd1;
                end
            FR_TAG:
                if (w == cfg_sep)
                begin
                    cnt_sep = bump(cnt_sep);
                    frame_phase = FR_PAY0;
                end
                else
                begin
                    close_line(w);
                end
            FR_PAY0:
            begin
                frame_phase = FR_PAY1;
                push_result(KIND_PAYLOAD, w, 1'b0, CLS_ACTIVE);
            end
            FR_PAY1:
            begin
                frame_phase = FR_LINETAG;
                push_result(KIND_PAYLOAD, w, 1'b1, CLS_ACTIVE);
            end
            FR_LINETAG:
                // no separator test here
                close_line(w);
            default:
            begin
                frame_phase = FR_PIXELS;
                pix_index = '0;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got);
        if (got !== exp_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, got);
            fail_count++;
        end
    endfunction

    function automatic logic [31:0] shadow_reg(input logic [1:0] idx);
        case (idx)
            REG_LINE_WORDS:    return {16'd0, cfg_line_words};
            REG_SEP_MARKER:    return cfg_sep;
            REG_ACTIVE_MARKER: return cfg_active;
            default:           return cfg_blank;
        endcase
    endfunction

    // Beat driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (capture_words.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                in_valid  <= 1'b1;
                data_word <= capture_words.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result sink back-pressure
    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on accepted words, check accepted results
    always @(posedge clk)
    begin : result_check
        line_result_t exp_r;
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
            deframe_word(data_word);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected (kind %0d)", result_kind);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("result_kind", 32'(exp_r.kind), 32'(result_kind));
                check_field("payload_word", exp_r.word, payload_word);
                check_field("payload_last", 32'(exp_r.last), 32'(payload_last));
                check_field("line_class", 32'(exp_r.cls), 32'(line_class));
                check_field("sep_total", exp_r.sep_t, sep_total);
                check_field("active_total", exp_r.act_t, active_total);
                check_field("blank_total", exp_r.blk_t, blank_total);
                check_field("unknown_total", exp_r.unk_t, unknown_total);
                results_checked++;
                if (exp_r.kind == KIND_PAYLOAD)
                    payload_seen++;
                else
                    line_ends_seen++;
            end
        end
    end

    task automatic read_reg(input logic [1:0] idx);
        logic [31:0] mask;
        mask = (idx == REG_LINE_WORDS) ? 32'h0000_ffff : 32'hffff_ffff;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== (shadow_reg(idx) & mask))
        begin
            $error("register %0d readback mismatch: expected %h, got %h",
                   idx, shadow_reg(idx), prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write, then read back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_LINE_WORDS:    cfg_line_words = value[15:0];
            REG_SEP_MARKER:    cfg_sep = value;
            REG_ACTIVE_MARKER: cfg_active = value;
            default:           cfg_blank = value;
        endcase
        reg_writes++;
        read_reg(idx);
    endtask

    task automatic queue_word(input logic [31:0] w);
        capture_words.push_back(w);
        words_queued++;
    endtask

    // Drain everything, then give the pipeline time to finish silent words
    task automatic wait_idle();
        while (capture_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_markers(input logic [31:0] s, input logic [31:0] a,
                               input logic [31:0] b);
        write_reg(REG_SEP_MARKER, s);
        write_reg(REG_ACTIVE_MARKER, a);
        write_reg(REG_BLANK_MARKER, b);
    endtask

    task automatic random_settings();
        logic [31:0] m;
        m = $urandom;
        write_reg(REG_LINE_WORDS, $urandom_range(6));
        case ($urandom_range(4))
            0:       set_markers($urandom, $urandom, $urandom);
            1:       set_markers($urandom, m, m);
            2:       set_markers(m, m, $urandom);
            3:       set_markers(m, $urandom, m);
            default: set_markers(SEP_MARKER_RESET, ACTIVE_MARKER_RESET, BLANK_MARKER_RESET);
        endcase
    endtask

    function automatic logic [31:0] pick_tag();
        case ($urandom_range(5))
            0, 1:    return cfg_active;
            2:       return cfg_blank;
            3:       return cfg_sep;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed lines; some with a pixel count one off
    task automatic queue_random_lines(input int n_words);
        int target;
        int npix;
        target = words_queued + n_words;
        while (words_queued < target)
        begin
            npix = (cfg_line_words == 0) ? 1 : int'(cfg_line_words);
            if ($urandom_range(9) == 0)
                npix = npix + int'($urandom_range(2)) - 1;
            repeat (npix) queue_word($urandom);
            if ($urandom_range(9) < 3)
            begin
                queue_word(cfg_sep);
                queue_word($urandom);
                queue_word($urandom);
            end
            queue_word(pick_tag());
        end
    endtask

    // Stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values of all registers
        read_reg(REG_LINE_WORDS);
        read_reg(REG_SEP_MARKER);
        read_reg(REG_ACTIVE_MARKER);
        read_reg(REG_BLANK_MARKER);

        // short lines with the reset markers: every class, a separator as line tag
        write_reg(REG_LINE_WORDS, 32'd2);
        queue_word(32'h0000_0000);
        queue_word(32'hffff_ffff);
        queue_word(ACTIVE_MARKER_RESET);
        queue_word($urandom);
        queue_word($urandom);
        queue_word(BLANK_MARKER_RESET);
        queue_word($urandom);
        queue_word($urandom);
        queue_word(32'h1234_5678);
        queue_word($urandom);
        queue_word($urandom);
        queue_word(SEP_MARKER_RESET);
        queue_word(32'hffff_ffff);
        queue_word(32'h0000_0000);
        queue_word(SEP_MARKER_RESET);
        wait_idle();

        // length shortened below the current position mid-line
        write_reg(REG_LINE_WORDS, 32'd5);
        repeat (3) queue_word($urandom);
        wait_idle();
        write_reg(REG_LINE_WORDS, 32'd2);
        queue_word($urandom);
        queue_word(ACTIVE_MARKER_RESET);
        wait_idle();

        // zero length acts as one
        write_reg(REG_LINE_WORDS, 32'd0);
        queue_word($urandom);
        queue_word(BLANK_MARKER_RESET);
        queue_word($urandom);
        queue_word(ACTIVE_MARKER_RESET);
        wait_idle();

        // all markers equal: separator wins, then the line tag is active
        write_reg(REG_LINE_WORDS, 32'd1);
        set_markers(32'h5a5a_a5a5, 32'h5a5a_a5a5, 32'h5a5a_a5a5);
        queue_word($urandom);
        queue_word(32'h5a5a_a5a5);
        queue_word($urandom);
        queue_word($urandom);
        queue_word(32'h5a5a_a5a5);
        wait_idle();
        set_markers(SEP_MARKER_RESET, 32'h0f0f_f0f0, 32'h0f0f_f0f0);
        queue_word($urandom);
        queue_word(32'h0f0f_f0f0);
        wait_idle();

        // largest length, then cut short partway through the line
        set_markers(SEP_MARKER_RESET, ACTIVE_MARKER_RESET, BLANK_MARKER_RESET);
        write_reg(REG_LINE_WORDS, 32'hffff);
        repeat (40) queue_word($urandom);
        wait_idle();
        write_reg(REG_LINE_WORDS, 32'd1);
        queue_word($urandom);
        queue_word(SEP_MARKER_RESET);
        queue_word($urandom);
        queue_word($urandom);
        queue_word(BLANK_MARKER_RESET);
        wait_idle();

        // random lines over the idling modes, new settings for each block
        for (int blk = 0; blk < 8; blk++)
        begin
            random_settings();
            case (blk % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 62;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 62;
                end
                default:
                begin
                    sender_idle_pct = 18;
                    recv_stall_pct  = 18;
                end
            endcase
            queue_random_lines(125);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("Run covered %0d capture words and %0d register writes.",
                 words_queued, reg_writes);
        $display("Checked %0d results: %0d payload beats, %0d line ends.",
                 results_checked, payload_seen, line_ends_seen);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
